### rtl/grbd_pkg.sv
// grbd_pkg: shared types and constants of the glyph run-length bit decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package grbd_pkg;

    // field widths
    localparam int PIX_W   = 8;
    localparam int CNT_W   = 6;
    localparam int BPP_W   = 4;
    localparam int TOTAL_W = 16;
    localparam int SEEN_W  = 4;

    // stream format
    localparam int COUNT_FIELD_BITS  = 6;
    localparam int REPEAT_ONES_LIMIT = 11;

    // reset values of the registers
    localparam logic [BPP_W-1:0]   BPP_RESET   = 4'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic CFG_BITS_PER_PIXEL = 1'b0;
    localparam logic CFG_PIXEL_TOTAL    = 1'b1;

    // decode state
    typedef enum logic [3:0] {
        MODE_SINGLE = 4'b0001,
        MODE_REPEAT = 4'b0010,
        MODE_COUNT  = 4'b0100,
        MODE_RAW    = 4'b1000
    } t_mode;

    // one run of identical pixels, final copy flagged when it ends the glyph
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        t_cmd head;
    } t_qstat;

endpackage

`default_nettype wire

### rtl/grbd_front.sv
// grbd_front: bit-serial field gathering, mode tracking and pixel accounting
// depends on grbd_pkg; pushes run commands into grbd_queue
`default_nettype none

module grbd_front
    import grbd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_stream_bit,
    output logic                    o_stall,
    input  wire logic [BPP_W-1:0]   i_bits_per_pixel,
    input  wire logic [TOTAL_W-1:0] i_pixel_total,
    input  wire logic               i_queue_full,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    t_mode              r_mode, n_mode;
    logic [PIX_W-1:0]   r_prev, n_prev;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [PIX_W-1:0]   r_shift, n_shift;
    logic [SEEN_W-1:0]  r_seen, n_seen;
    logic [TOTAL_W-1:0] r_emitted, n_emitted;

    logic               accept;
    logic [SEEN_W-1:0]  depth;
    logic [PIX_W-1:0]   gath_shift;
    logic [SEEN_W-1:0]  gath_seen;
    logic [TOTAL_W-1:0] to_end;
    logic [CNT_W-1:0]   run_cnt;
    logic               rep;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;

    // effective pixel depth, clamped to 1..8
    always_comb begin
        if (i_bits_per_pixel == '0) begin
            depth = SEEN_W'(1);
        end else if (i_bits_per_pixel > BPP_W'(PIX_W)) begin
            depth = SEEN_W'(PIX_W);
        end else begin
            depth = i_bits_per_pixel;
        end
    end

    // shift in the new bit, pixels left before the final one
    assign gath_shift = {r_shift[PIX_W-2:0], i_stream_bit};
    assign gath_seen  = r_seen + SEEN_W'(1);
    assign to_end     = i_pixel_total - r_emitted - TOTAL_W'(1);
    assign run_cnt    = gath_shift[CNT_W-1:0];
    assign rep        = (r_mode == MODE_SINGLE) && (r_emitted != '0) && (gath_shift == r_prev);

    // next state and command per accepted stream bit
    always_comb begin
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_run     = r_run;
        n_shift   = r_shift;
        n_seen    = r_seen;
        n_emitted = r_emitted;
        o_push    = 1'b0;
        o_cmd     = '{value: r_prev, count: CNT_W'(1), last: 1'b0};

        if (accept) begin
            case (r_mode)
                MODE_SINGLE, MODE_RAW: begin
                    n_shift = gath_shift;
                    n_seen  = gath_seen;
                    if (gath_seen >= depth) begin
                        o_push    = 1'b1;
                        o_cmd     = '{value: gath_shift, count: CNT_W'(1),
                                      last: (to_end == '0)};
                        n_shift   = '0;
                        n_seen    = '0;
                        n_prev    = gath_shift;
                        n_emitted = r_emitted + TOTAL_W'(1);
                        if (rep) begin
                            n_mode = MODE_REPEAT;
                            n_run  = '0;
                        end else begin
                            n_mode = MODE_SINGLE;
                        end
                    end
                end
                MODE_REPEAT: begin
                    n_run = r_run + CNT_W'(1);
                    if (i_stream_bit) begin
                        if (n_run == CNT_W'(REPEAT_ONES_LIMIT)) begin
                            n_mode  = MODE_COUNT;
                            n_shift = '0;
                            n_seen  = '0;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd     = '{value: r_prev, count: CNT_W'(1),
                                          last: (to_end == '0)};
                            n_emitted = r_emitted + TOTAL_W'(1);
                        end
                    end else begin
                        n_mode  = MODE_RAW;
                        n_shift = '0;
                        n_seen  = '0;
                    end
                end
                MODE_COUNT: begin
                    n_shift = gath_shift;
                    n_seen  = gath_seen;
                    if (gath_seen >= SEEN_W'(COUNT_FIELD_BITS)) begin
                        n_shift = '0;
                        n_seen  = '0;
                        n_run   = '0;
                        n_mode  = MODE_RAW;
                        if (run_cnt != '0) begin
                            o_push = 1'b1;
                            if (to_end < TOTAL_W'(run_cnt)) begin
                                // run cut short by the end of the glyph
                                o_cmd = '{value: r_prev,
                                          count: to_end[CNT_W-1:0] + CNT_W'(1),
                                          last: 1'b1};
                            end else begin
                                o_cmd = '{value: r_prev, count: run_cnt, last: 1'b0};
                            end
                            n_emitted = r_emitted + TOTAL_W'(run_cnt);
                        end
                    end
                end
                default: begin
                    n_mode = MODE_SINGLE;
                end
            endcase

            // end of glyph: rearm for the next one
            if (o_push && o_cmd.last) begin
                n_mode    = MODE_SINGLE;
                n_prev    = '0;
                n_run     = '0;
                n_shift   = '0;
                n_seen    = '0;
                n_emitted = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SINGLE;
            r_prev    <= '0;
            r_run     <= '0;
            r_shift   <= '0;
            r_seen    <= '0;
            r_emitted <= '0;
        end else begin
            r_mode    <= n_mode;
            r_prev    <= n_prev;
            r_run     <= n_run;
            r_shift   <= n_shift;
            r_seen    <= n_seen;
            r_emitted <= n_emitted;
        end
    end

endmodule

`default_nettype wire

### rtl/grbd_queue.sv
// grbd_queue: small command fifo between the front and back ends
// depends on grbd_pkg for the command type and depth
`default_nettype none

module grbd_queue
    import grbd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output t_qstat    o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_fill, n_fill;

    assign o_full = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat = '{empty: (r_fill == '0), head: r_mem[r_rd]};

    // pointer and fill updates
    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_fill = r_fill;
        if (i_push) begin
            n_wr = r_wr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + (QPTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - (QPTR_W+1)'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

### rtl/grbd_back.sv
// grbd_back: expands run commands into pixel words behind an output register
// depends on grbd_pkg; reads the head of grbd_queue
`default_nettype none

module grbd_back
    import grbd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_qstat        i_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [PIX_W-1:0]   o_pixel_value,
    output logic               o_last_pixel
);

    logic [CNT_W-1:0] r_idx;
    logic             r_valid;
    logic [PIX_W-1:0] r_value;
    logic             r_last;

    logic             load;
    logic             take;
    logic             final_copy;

    // output register may refill when empty or being taken
    assign load       = !r_valid || !i_stall;
    assign take       = load && !i_stat.empty;
    assign final_copy = (r_idx + CNT_W'(1)) == i_stat.head.count;
    assign o_pop      = take && final_copy;

    assign o_valid       = r_valid;
    assign o_pixel_value = r_value;
    assign o_last_pixel  = r_last;

    // copy counter and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_idx   <= final_copy ? '0 : r_idx + CNT_W'(1);
        end else if (load) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= i_stat.head.value;
            r_last  <= i_stat.head.last && final_copy;
        end
    end

endmodule

`default_nettype wire

### rtl/glyph_rle_bit_decoder_core.sv
// a bit that completes a pixel passes through the command queue and then the output register to o_valid
// throughput: one stream bit per cycle while the command queue is not full; a run of N copies
// gives N output words, and the four-entry command queue stalls the stream while the output drains
// reset: synchronous active-low i_rst_n empties the queue and output register,
// restores decode state, and sets bits_per_pixel to 4 and pixel_total to 1
// top level: configuration registers and the front / queue / back pipeline
// depends on grbd_pkg, grbd_front, grbd_queue, grbd_back
`default_nettype none

module glyph_rle_bit_decoder_core
    import grbd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_stream_bit,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [PIX_W-1:0]        o_pixel_value,
    output logic                    o_last_pixel,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [TOTAL_W-1:0] i_cfg_data
);

    logic [BPP_W-1:0]   r_bits_per_pixel;
    logic [TOTAL_W-1:0] r_pixel_total;

    logic   queue_full;
    logic   push;
    t_cmd   cmd;
    logic   pop;
    t_qstat qstat;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_per_pixel <= BPP_RESET;
            r_pixel_total    <= TOTAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BITS_PER_PIXEL: r_bits_per_pixel <= i_cfg_data[BPP_W-1:0];
                CFG_PIXEL_TOTAL:    r_pixel_total    <= i_cfg_data;
                default:            r_pixel_total    <= r_pixel_total;
            endcase
        end
    end

    // stream decode
    grbd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_stream_bit     (i_stream_bit),
        .o_stall          (o_stall),
        .i_bits_per_pixel (r_bits_per_pixel),
        .i_pixel_total    (r_pixel_total),
        .i_queue_full     (queue_full),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    // run commands in flight
    grbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_stat  (qstat)
    );

    // pixel output
    grbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stat        (qstat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

`default_nettype wire
